/* src/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define BSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequent holds in the cycle after the trigger
`define BSC_ASSERT_NEXT(lbl, clk, rst, trig, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

/* src/bsc_pkg.sv */
// types and constants of the banker's safety check
// no dependencies
`default_nettype none

package bsc_pkg;

   localparam int UNIT_W = 16;
   localparam logic [UNIT_W-1:0] UNIT_MAX = 16'hFFFF;

   localparam logic [2:0] OP_WRITE_NEED   = 3'd0;
   localparam logic [2:0] OP_WRITE_HELD   = 3'd1;
   localparam logic [2:0] OP_WRITE_AVAIL  = 3'd2;
   localparam logic [2:0] OP_CLEAR_MARKS  = 3'd3;
   localparam logic [2:0] OP_RUN_CHECK    = 3'd4;

   localparam logic KIND_COMPLETED = 1'b0;
   localparam logic KIND_SUMMARY   = 1'b1;

   localparam logic CSR_PROCESS_COUNT  = 1'b0;
   localparam logic CSR_RESOURCE_COUNT = 1'b1;

   localparam logic [4:0] PROCESS_COUNT_RESET  = 5'd16;
   localparam logic [3:0] RESOURCE_COUNT_RESET = 4'd8;

   typedef struct packed {
      logic [2:0]        opcode;
      logic [3:0]        process_index;
      logic [2:0]        resource_index;
      logic [UNIT_W-1:0] unit_value;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [3:0] completed_process;
      logic       all_finished;
      logic [4:0] finished_total;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic need_we;
      logic held_we;
   } tbl_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COUNT,
      ST_SCAN,
      ST_CHK_RD,
      ST_CHK_CMP,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_EMIT,
      ST_SUMMARY
   } state_type;

endpackage

`default_nettype wire

/* src/bsc_table_mem.sv */
// single-port-write, single-port-read table memory with registered read data
// depends on bsc_pkg
`default_nettype none

module bsc_table_mem
   import bsc_pkg::*;
#(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [UNIT_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [UNIT_W-1:0] rd_data
);

   logic [UNIT_W-1:0] mem_ff [DEPTH];
   logic [UNIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/bsc_ctrl.sv */
// sequencer of the safety check: load decode, available vector, finished marks
// depends on bsc_pkg; drives the two table memories
`default_nettype none

module bsc_ctrl
   import bsc_pkg::*;
#(
   parameter int MAX_PROCESSES = 16,
   parameter int MAX_RESOURCES = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_type       req_data,
   input  wire logic [$clog2(MAX_PROCESSES+1)-1:0] proc_lim,
   input  wire logic [$clog2(MAX_RESOURCES+1)-1:0] res_lim,
   input  wire logic          slot_free,
   input  wire logic [UNIT_W-1:0] need_q,
   input  wire logic [UNIT_W-1:0] held_q,
   output tbl_ctl_type        tbl_ctl,
   output logic [((MAX_PROCESSES*MAX_RESOURCES > 1) ?
                  $clog2(MAX_PROCESSES*MAX_RESOURCES) : 1)-1:0] wr_addr,
   output logic [UNIT_W-1:0]  wr_data,
   output logic [((MAX_PROCESSES*MAX_RESOURCES > 1) ?
                  $clog2(MAX_PROCESSES*MAX_RESOURCES) : 1)-1:0] rd_addr,
   output logic               emit_valid,
   output rsp_type            emit_data
);

   localparam int CW  = $clog2(MAX_PROCESSES + 1);
   localparam int RCW = $clog2(MAX_RESOURCES + 1);
   localparam int PIW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int RIW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int AW  = (MAX_PROCESSES*MAX_RESOURCES > 1) ?
                        $clog2(MAX_PROCESSES*MAX_RESOURCES) : 1;

   state_type         state_ff, state_in;
   logic [CW-1:0]     i_ff, i_in;
   logic [RCW-1:0]    j_ff, j_in;
   logic [CW-1:0]     total_ff, total_in;
   logic              progress_ff, progress_in;
   logic [CW-1:0]     np_ff, np_in;
   logic [RCW-1:0]    nr_ff, nr_in;
   logic [UNIT_W-1:0] avail_ff [MAX_RESOURCES];
   logic              marks_ff [MAX_PROCESSES];

   logic              avail_we;
   logic [RIW-1:0]    avail_idx;
   logic [UNIT_W-1:0] avail_val;
   logic              mark_set;
   logic              marks_clear;
   logic [UNIT_W-1:0] avail_rd;
   logic              mark_rd;
   logic [UNIT_W:0]   sat_sum;
   logic              load_ok;

   assign avail_rd = avail_ff[RIW'(j_ff)];
   assign mark_rd  = marks_ff[PIW'(i_ff)];
   assign sat_sum  = {1'b0, avail_rd} + {1'b0, held_q};
   assign load_ok  = (32'(req_data.process_index) < MAX_PROCESSES) &&
                     (32'(req_data.resource_index) < MAX_RESOURCES);
   assign wr_addr  = AW'(32'(req_data.process_index) * MAX_RESOURCES +
                         32'(req_data.resource_index));
   assign wr_data  = req_data.unit_value;
   assign rd_addr  = AW'(32'(i_ff) * MAX_RESOURCES + 32'(j_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         i_ff        <= '0;
         j_ff        <= '0;
         total_ff    <= '0;
         progress_ff <= 1'b0;
         np_ff       <= '0;
         nr_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         total_ff    <= total_in;
         progress_ff <= progress_in;
         np_ff       <= np_in;
         nr_ff       <= nr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (avail_we) begin
         avail_ff[avail_idx] <= avail_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || marks_clear) begin
         for (int p = 0; p < MAX_PROCESSES; p++) begin
            marks_ff[p] <= 1'b0;
         end
      end else if (mark_set) begin
         marks_ff[PIW'(i_ff)] <= 1'b1;
      end
   end

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      total_in    = total_ff;
      progress_in = progress_ff;
      np_in       = np_ff;
      nr_in       = nr_ff;
      req_ready   = 1'b0;
      tbl_ctl     = '0;
      avail_we    = 1'b0;
      avail_idx   = RIW'(j_ff);
      avail_val   = sat_sum[UNIT_W] ? UNIT_MAX : sat_sum[UNIT_W-1:0];
      mark_set    = 1'b0;
      marks_clear = 1'b0;
      emit_valid  = 1'b0;
      emit_data   = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_data.opcode)
                  OP_WRITE_NEED: begin
                     tbl_ctl.need_we = load_ok;
                  end
                  OP_WRITE_HELD: begin
                     tbl_ctl.held_we = load_ok;
                  end
                  OP_WRITE_AVAIL: begin
                     avail_we  = 32'(req_data.resource_index) < MAX_RESOURCES;
                     avail_idx = RIW'(req_data.resource_index);
                     avail_val = req_data.unit_value;
                  end
                  OP_CLEAR_MARKS: begin
                     marks_clear = 1'b1;
                  end
                  OP_RUN_CHECK: begin
                     np_in    = proc_lim;
                     nr_in    = res_lim;
                     i_in     = '0;
                     total_in = '0;
                     state_in = ST_COUNT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // count marks already set among the active processes
         ST_COUNT: begin
            if (i_ff == np_ff) begin
               i_in        = '0;
               progress_in = 1'b0;
               state_in    = ST_SCAN;
            end else begin
               total_in = total_ff + CW'(mark_rd);
               i_in     = i_ff + CW'(1);
            end
         end
         ST_SCAN: begin
            if (i_ff == np_ff) begin
               if (progress_ff) begin
                  i_in        = '0;
                  progress_in = 1'b0;
               end else begin
                  state_in = ST_SUMMARY;
               end
            end else if (mark_rd) begin
               i_in = i_ff + CW'(1);
            end else begin
               j_in     = '0;
               state_in = ST_CHK_RD;
            end
         end
         ST_CHK_RD: begin
            if (j_ff == nr_ff) begin
               j_in     = '0;
               state_in = ST_ADD_RD;
            end else begin
               state_in = ST_CHK_CMP;
            end
         end
         ST_CHK_CMP: begin
            if (need_q > avail_rd) begin
               i_in     = i_ff + CW'(1);
               state_in = ST_SCAN;
            end else begin
               j_in     = j_ff + RCW'(1);
               state_in = ST_CHK_RD;
            end
         end
         ST_ADD_RD: begin
            if (j_ff == nr_ff) begin
               mark_set    = 1'b1;
               total_in    = total_ff + CW'(1);
               progress_in = 1'b1;
               state_in    = ST_EMIT;
            end else begin
               state_in = ST_ADD_WR;
            end
         end
         ST_ADD_WR: begin
            avail_we = 1'b1;
            j_in     = j_ff + RCW'(1);
            state_in = ST_ADD_RD;
         end
         ST_EMIT: begin
            emit_data.result_kind       = KIND_COMPLETED;
            emit_data.completed_process = 4'(i_ff);
            emit_data.finished_total    = 5'(total_ff);
            if (slot_free) begin
               emit_valid = 1'b1;
               i_in       = i_ff + CW'(1);
               state_in   = ST_SCAN;
            end
         end
         ST_SUMMARY: begin
            emit_data.result_kind    = KIND_SUMMARY;
            emit_data.all_finished   = (total_ff == np_ff);
            emit_data.finished_total = 5'(total_ff);
            emit_data.last_of_run    = 1'b1;
            if (slot_free) begin
               emit_valid = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* src/bankers_safety_check.sv */
// banker's safety check: top level with count registers and result register
// depends on bsc_pkg, bsc_table_mem, bsc_ctrl
//
// req channel: one operation per transfer (load need, load held, load available,
// clear finished marks, run). Loads and clear give no result.
// rsp channel: a run gives one completion result per process that finishes, in
// pass order, then a summary result with last_of_run set.
// csr port: process_count and resource_count, written any cycle, no read-back.
// A run first counts the marks already set, then makes passes over the processes
// until a pass finishes none: each unfinished process is compared resource by
// resource, and each process that finishes adds its held units to the available
// vector one resource at a time, then gives its result; all steps are set by the
// single read port of the two table memories.
// req_ready is low from the run transfer until its summary enters the result
// register. Results go through a one-entry register: a stalled receiver holds
// the sequencer while a new result waits, and no loads are taken meanwhile.
// Reset clears the finished marks and sets the counts to 16 and 8; table and
// available entries hold nothing defined until written.
`default_nettype none

module bankers_safety_check
   import bsc_pkg::*;
#(
   parameter int MAX_PROCESSES = 16,
   parameter int MAX_RESOURCES = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [4:0] csr_wdata
);

   localparam int CW    = $clog2(MAX_PROCESSES + 1);
   localparam int RCW   = $clog2(MAX_RESOURCES + 1);
   localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [4:0]        process_count_ff;
   logic [3:0]        resource_count_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic [CW-1:0]     proc_lim;
   logic [RCW-1:0]    res_lim;
   logic              slot_free;
   tbl_ctl_type       tbl_ctl;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic [UNIT_W-1:0] wr_data;
   logic [UNIT_W-1:0] need_q;
   logic [UNIT_W-1:0] held_q;
   logic              emit_valid;
   rsp_type           emit_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         process_count_ff  <= PROCESS_COUNT_RESET;
         resource_count_ff <= RESOURCE_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PROCESS_COUNT:  process_count_ff  <= csr_wdata;
            CSR_RESOURCE_COUNT: resource_count_ff <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // clamp counts to the table size
   assign proc_lim = (32'(process_count_ff) > MAX_PROCESSES) ?
                     CW'(MAX_PROCESSES) : CW'(process_count_ff);
   assign res_lim  = (32'(resource_count_ff) > MAX_RESOURCES) ?
                     RCW'(MAX_RESOURCES) : RCW'(resource_count_ff);

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bsc_table_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_need_mem (
      .clock   (clock),
      .we      (tbl_ctl.need_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (need_q)
   );

   bsc_table_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_held_mem (
      .clock   (clock),
      .we      (tbl_ctl.held_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (held_q)
   );

   bsc_ctrl #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .MAX_RESOURCES (MAX_RESOURCES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .proc_lim   (proc_lim),
      .res_lim    (res_lim),
      .slot_free  (slot_free),
      .need_q     (need_q),
      .held_q     (held_q),
      .tbl_ctl    (tbl_ctl),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .emit_valid (emit_valid),
      .emit_data  (emit_data)
   );

endmodule

`default_nettype wire

/* src/bsc_checker.sv */
// port-level checks of the banker's safety check, bound to the top level
// depends on bsc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bsc_checker
   import bsc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // a stalled result keeps its transfer pending unchanged
   `BSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // a run keeps the request side closed on the next cycle
   `BSC_ASSERT_NEXT(a_run_busy, clock, reset, req_valid && req_ready && req_data.opcode == OP_RUN_CHECK, !req_ready, "request taken during run")

   // summary shape
   `BSC_ASSERT(a_summary_shape, clock, reset, rsp_valid && rsp_data.result_kind == KIND_SUMMARY |-> rsp_data.last_of_run && rsp_data.completed_process == 4'd0, "bad summary result")

   // completion shape
   `BSC_ASSERT(a_done_shape, clock, reset, rsp_valid && rsp_data.result_kind == KIND_COMPLETED |-> !rsp_data.last_of_run && !rsp_data.all_finished, "bad completion result")

endmodule

bind bankers_safety_check bsc_checker u_bsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
